@@ hdl/bfa_pkg.sv @@
// shared constants and types of the best-fit block allocator
package bfa_pkg;

    // default table depth and block size width
    localparam int MAX_BLOCKS_DEF = 32;
    localparam int SIZE_BITS_DEF  = 24;

    // fixed field widths of the ports
    localparam int INDEX_FIELD_W = 5;
    localparam int CFG_W         = 6;

    // request kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_ALLOC = 1'b1;

    // broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic load_en;
        logic alloc_en;
    } bfa_ctrl_t;

endpackage

@@ hdl/bfa_if.sv @@
// request and result channel interfaces of the best-fit block allocator
interface bfa_in_if
    import bfa_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
);
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [INDEX_FIELD_W-1:0] block_index;
    logic [SIZE_BITS-1:0]     size;

    modport source (output valid, kind, block_index, size, input ready);
    modport sink (input valid, kind, block_index, size, output ready);
endinterface

interface bfa_out_if
    import bfa_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
);
    logic                     valid;
    logic                     ready;
    logic                     found;
    logic [INDEX_FIELD_W-1:0] chosen_block;
    logic [SIZE_BITS-1:0]     fragment;

    modport source (output valid, found, chosen_block, fragment, input ready);
    modport sink (input valid, found, chosen_block, fragment, output ready);
endinterface

@@ hdl/bfa_cell.sv @@
// one table entry: block size, allocated mark and one stage of the search chain
module bfa_cell
    import bfa_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF,
    parameter int CELL_IDX   = 0,
    localparam int IDX_W     = $clog2(MAX_BLOCKS)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  bfa_ctrl_t                ctrl,
    input  logic [INDEX_FIELD_W-1:0] load_idx,
    input  logic [SIZE_BITS-1:0]     load_size,
    input  logic [IDX_W-1:0]         alloc_idx,
    input  logic [CFG_W-1:0]         num_blocks,
    input  logic                     tok_valid_in,
    input  logic                     tok_have_in,
    input  logic [SIZE_BITS-1:0]     tok_rem_in,
    input  logic [IDX_W-1:0]         tok_idx_in,
    input  logic [SIZE_BITS-1:0]     tok_req_in,
    output logic                     tok_valid_out,
    output logic                     tok_have_out,
    output logic [SIZE_BITS-1:0]     tok_rem_out,
    output logic [IDX_W-1:0]         tok_idx_out,
    output logic [SIZE_BITS-1:0]     tok_req_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [SIZE_BITS-1:0] size_reg;
    logic                 mark_reg;
    logic                 mark_next;
    logic                 load_hit;
    logic                 alloc_hit;
    logic                 in_range;
    logic                 fits;
    logic                 take;
    logic [SIZE_BITS-1:0] rem;

    logic                 tok_valid_reg;
    logic                 tok_have_reg;
    logic [SIZE_BITS-1:0] tok_rem_reg;
    logic [IDX_W-1:0]     tok_idx_reg;
    logic [SIZE_BITS-1:0] tok_req_reg;

    // address decode of the broadcasts
    assign load_hit  = ctrl.load_en && (int'(load_idx) == CELL_IDX);
    assign alloc_hit = ctrl.alloc_en && (alloc_idx == MY_IDX);
    assign in_range  = (CELL_IDX < int'(num_blocks));

    // mark update: a load frees the entry, an allocation takes it
    always_comb
    begin
        mark_next = mark_reg;
        if (load_hit)
        begin
            mark_next = 1'b0;
        end
        else if (alloc_hit)
        begin
            mark_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg <= 1'b0;
        end
        else
        begin
            mark_reg <= mark_next;
        end
    end

    // block size store
    always_ff @(posedge clk)
    begin
        if (load_hit)
        begin
            size_reg <= load_size;
        end
    end

    // compare against the best candidate so far
    assign fits = tok_valid_in && in_range && !mark_reg && (size_reg >= tok_req_in);
    assign rem  = size_reg - tok_req_in;
    assign take = fits && (!tok_have_in || (rem < tok_rem_in));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_valid_in;
        end
    end

    // hand the candidate on to the next cell
    always_ff @(posedge clk)
    begin
        tok_have_reg <= tok_have_in || take;
        tok_rem_reg  <= take ? rem : tok_rem_in;
        tok_idx_reg  <= take ? MY_IDX : tok_idx_in;
        tok_req_reg  <= tok_req_in;
    end

    assign tok_valid_out = tok_valid_reg;
    assign tok_have_out  = tok_have_reg;
    assign tok_rem_out   = tok_rem_reg;
    assign tok_idx_out   = tok_idx_reg;
    assign tok_req_out   = tok_req_reg;

endmodule

@@ hdl/best_fit_block_allocator.sv @@
// best-fit allocator: a load gives no result
// an allocation request gives its result in the output register after the search
// the search token walks the row of cells, one table entry per cycle
// a new item is accepted once the previous result sits in the output register,
// so back to back allocations do not overlap
// reset clears all allocated marks and num_blocks; block sizes stay unknown until loaded
module best_fit_block_allocator
    import bfa_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    bfa_in_if.sink           items,
    bfa_out_if.source        results
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]         num_blocks_reg;
    logic                     in_accept;
    logic                     out_free;
    bfa_ctrl_t                ctrl;

    logic                     inj_valid_reg;
    logic [SIZE_BITS-1:0]     inj_req_reg;

    logic                     tok_valid [0:MAX_BLOCKS];
    logic                     tok_have  [0:MAX_BLOCKS];
    logic [SIZE_BITS-1:0]     tok_rem   [0:MAX_BLOCKS];
    logic [IDX_W-1:0]         tok_idx   [0:MAX_BLOCKS];
    logic [SIZE_BITS-1:0]     tok_req   [0:MAX_BLOCKS];

    logic                     done_have_reg;
    logic [SIZE_BITS-1:0]     done_rem_reg;
    logic [IDX_W-1:0]         done_idx_reg;

    logic                     res_valid_reg;
    logic                     res_found_reg;
    logic [INDEX_FIELD_W-1:0] res_block_reg;
    logic [SIZE_BITS-1:0]     res_frag_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_blocks_reg <= '0;
        end
        else if (cfg_we)
        begin
            num_blocks_reg <= cfg_wdata;
        end
    end

    // handshakes
    assign items.ready = (state_reg == S_IDLE);
    assign in_accept   = items.valid && items.ready;
    assign out_free    = !res_valid_reg || results.ready;

    // broadcasts to the cells
    assign ctrl.load_en  = in_accept && (items.kind == KIND_LOAD);
    assign ctrl.alloc_en = (state_reg == S_FINISH) && out_free && done_have_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (items.kind == KIND_ALLOC))
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (tok_valid[MAX_BLOCKS])
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            inj_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            inj_valid_reg <= in_accept && (items.kind == KIND_ALLOC);
        end
    end

    // search token entering the first cell
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            inj_req_reg <= items.size;
        end
    end

    assign tok_valid[0] = inj_valid_reg;
    assign tok_have[0]  = 1'b0;
    assign tok_rem[0]   = '0;
    assign tok_idx[0]   = '0;
    assign tok_req[0]   = inj_req_reg;

    // row of table cells
    for (genvar i = 0; i < MAX_BLOCKS; i++)
    begin : g_cell
        bfa_cell #(
            .MAX_BLOCKS (MAX_BLOCKS),
            .SIZE_BITS  (SIZE_BITS),
            .CELL_IDX   (i)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (ctrl),
            .load_idx      (items.block_index),
            .load_size     (items.size),
            .alloc_idx     (done_idx_reg),
            .num_blocks    (num_blocks_reg),
            .tok_valid_in  (tok_valid[i]),
            .tok_have_in   (tok_have[i]),
            .tok_rem_in    (tok_rem[i]),
            .tok_idx_in    (tok_idx[i]),
            .tok_req_in    (tok_req[i]),
            .tok_valid_out (tok_valid[i+1]),
            .tok_have_out  (tok_have[i+1]),
            .tok_rem_out   (tok_rem[i+1]),
            .tok_idx_out   (tok_idx[i+1]),
            .tok_req_out   (tok_req[i+1])
        );
    end

    // capture the winner leaving the last cell
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_SEARCH) && tok_valid[MAX_BLOCKS])
        begin
            done_have_reg <= tok_have[MAX_BLOCKS];
            done_rem_reg  <= tok_rem[MAX_BLOCKS];
            done_idx_reg  <= tok_idx[MAX_BLOCKS];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_FINISH) && out_free)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_FINISH) && out_free)
        begin
            res_found_reg <= done_have_reg;
            res_block_reg <= done_have_reg ? INDEX_FIELD_W'(done_idx_reg) : '0;
            res_frag_reg  <= done_have_reg ? done_rem_reg : '0;
        end
    end

    assign results.valid        = res_valid_reg;
    assign results.found        = res_found_reg;
    assign results.chosen_block = res_block_reg;
    assign results.fragment     = res_frag_reg;

endmodule

@@ sim/bfa_alloc_checker.sv @@
// scoreboard of the best-fit allocator: predicts each allocation result and compares it
`timescale 1ns / 1ps

module bfa_alloc_checker
    import bfa_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    bfa_in_if                items,
    bfa_out_if               results,
    output int               due_count,
    output int               error_count
);

    typedef struct packed {
        logic                     found;
        logic [INDEX_FIELD_W-1:0] chosen_block;
        logic [SIZE_BITS-1:0]     fragment;
    } alloc_result_t;

    // private copy of the table, the marks and the search span
    logic [SIZE_BITS-1:0] block_size_copy [MAX_BLOCKS];
    logic                 taken_copy [MAX_BLOCKS];
    logic [CFG_W-1:0]     searched_copy;
    alloc_result_t        alloc_results_due [$];
    alloc_result_t        want_result;
    alloc_result_t        got_result;

    // best fit over the searched entries, lowest index wins a tie; marks the winner
    function automatic alloc_result_t best_fit_pick(input logic [SIZE_BITS-1:0] want);
        alloc_result_t        pick;
        int                   span;
        logic [SIZE_BITS-1:0] rem;
        pick = '0;
        span = (int'(searched_copy) > MAX_BLOCKS) ? MAX_BLOCKS : int'(searched_copy);
        for (int j = 0; j < span; j++)
        begin
            if (!taken_copy[j] && block_size_copy[j] >= want)
            begin
                rem = block_size_copy[j] - want;
                if (!pick.found || rem < pick.fragment)
                begin
                    pick.found        = 1'b1;
                    pick.chosen_block = INDEX_FIELD_W'(j);
                    pick.fragment     = rem;
                end
            end
        end
        if (pick.found)
            taken_copy[pick.chosen_block] = 1'b1;
        return pick;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_BLOCKS; j++)
                taken_copy[j] = 1'b0;
            searched_copy = '0;
            alloc_results_due.delete();
            due_count   = 0;
            error_count = 0;
        end
        else
        begin
            // results first: one accepted at this edge belongs to an older request
            if (results.valid && results.ready)
            begin
                got_result = '{results.found, results.chosen_block, results.fragment};
                if (alloc_results_due.size() == 0)
                begin
                    $error("result with no allocation request outstanding");
                    error_count++;
                end
                else
                begin
                    want_result = alloc_results_due.pop_front();
                    check_field("found", 32'(want_result.found), 32'(got_result.found));
                    check_field("chosen_block", 32'(want_result.chosen_block),
                                32'(got_result.chosen_block));
                    check_field("fragment", 32'(want_result.fragment),
                                32'(got_result.fragment));
                end
            end

            // accepted request: load writes the table, allocation queues a result
            if (items.valid && items.ready)
            begin
                if (items.kind == KIND_LOAD)
                begin
                    if (int'(items.block_index) < MAX_BLOCKS)
                    begin
                        block_size_copy[items.block_index] = items.size;
                        taken_copy[items.block_index]      = 1'b0;
                    end
                end
                else
                    alloc_results_due.push_back(best_fit_pick(items.size));
            end

            // register write
            if (cfg_we)
                searched_copy = cfg_wdata;

            due_count = alloc_results_due.size();
        end
    end

endmodule

@@ sim/tb_top.sv @@
// top of the allocator testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
    import bfa_pkg::*;

    localparam int MAX_BLOCKS     = MAX_BLOCKS_DEF;
    localparam int SIZE_BITS      = SIZE_BITS_DEF;
    localparam int RESULT_LATENCY = MAX_BLOCKS + 3;
    localparam int STALL_LIMIT    = 1000;
    localparam int PHASE_ITEMS    = 100;
    localparam int PHASE_COUNT    = 12;
    localparam int PICK_RANDOM    = -1;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    logic             calm;
    int               due_count;
    int               error_count;
    int               stall_cycles = 0;
    int               ready_hold   = 0;
    int               searched_now;
    logic [SIZE_BITS-1:0] loaded_sizes [MAX_BLOCKS];
    int phase_settings [PHASE_COUNT] = '{32, 63, 1, 33, PICK_RANDOM, 0, 2, PICK_RANDOM,
                                          31, PICK_RANDOM, 63, 32};

    bfa_in_if  #(.SIZE_BITS(SIZE_BITS)) items_ch ();
    bfa_out_if #(.SIZE_BITS(SIZE_BITS)) results_ch ();

    best_fit_block_allocator #(
        .MAX_BLOCKS(MAX_BLOCKS),
        .SIZE_BITS (SIZE_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .items    (items_ch),
        .results  (results_ch)
    );

    bfa_alloc_checker #(
        .MAX_BLOCKS(MAX_BLOCKS),
        .SIZE_BITS (SIZE_BITS)
    ) alloc_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .items      (items_ch),
        .results    (results_ch),
        .due_count  (due_count),
        .error_count(error_count)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // random result side back-pressure in bursts, none started while calm
    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            results_ch.ready <= 1'b0;
            ready_hold = ready_hold - 1;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            results_ch.ready <= 1'b0;
            ready_hold = $urandom_range(0, 2);
        end
        else
            results_ch.ready <= 1'b1;
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // one request, with an optional idle burst ahead of it
    task automatic push_request(input logic kind, input logic [INDEX_FIELD_W-1:0] idx,
                                input logic [SIZE_BITS-1:0] size);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            repeat (gap)
            begin
                @(negedge clk);
                items_ch.valid <= 1'b0;
            end
        end
        @(negedge clk);
        items_ch.valid       <= 1'b1;
        items_ch.kind        <= kind;
        items_ch.block_index <= idx;
        items_ch.size        <= size;
        if (kind == KIND_LOAD)
            loaded_sizes[idx] = size;
        do
            @(posedge clk);
        while (items_ch.ready !== 1'b1);
    endtask

    // drain all results, then let a trailing load finish
    task automatic settle();
        @(negedge clk);
        items_ch.valid <= 1'b0;
        while (due_count != 0)
            @(negedge clk);
        repeat (RESULT_LATENCY) @(negedge clk);
    endtask

    task automatic write_num_blocks(input int value);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= CFG_W'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        searched_now = value;
    endtask

    // mostly loads and allocations aimed at the searched entries, some noise
    task automatic random_request();
        int                       span;
        int                       pick;
        logic                     kind;
        logic [INDEX_FIELD_W-1:0] idx;
        logic [SIZE_BITS-1:0]     size;
        span = (searched_now > MAX_BLOCKS) ? MAX_BLOCKS : searched_now;
        idx  = INDEX_FIELD_W'($urandom_range(0, MAX_BLOCKS - 1));
        size = SIZE_BITS'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 10)
            kind = 1'($urandom_range(0, 1));
        else
        begin
            kind = (pick < 46) ? KIND_LOAD : KIND_ALLOC;
            if (kind == KIND_LOAD && span > 0)
                idx = INDEX_FIELD_W'($urandom_range(0, span - 1));
            case ($urandom_range(0, 3))
                0: size = SIZE_BITS'($urandom_range(0, 15));
                1: size = SIZE_BITS'($urandom_range(0, 255));
                2:
                begin
                    // near a size already in the table, exact fits and misses by one
                    if (span > 0)
                        size = loaded_sizes[$urandom_range(0, span - 1)]
                               + SIZE_BITS'($urandom_range(0, 2)) - SIZE_BITS'(1);
                end
                default: ;
            endcase
        end
        push_request(kind, idx, size);
    endtask

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        calm                 = 1'b0;
        searched_now         = 0;
        items_ch.valid       = 1'b0;
        items_ch.kind        = KIND_LOAD;
        items_ch.block_index = '0;
        items_ch.size        = '0;
        results_ch.ready     = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero blocks after reset: nothing is searched, nothing found
        push_request(KIND_ALLOC, 5'd0, '0);
        push_request(KIND_ALLOC, 5'd31, '1);

        // small table with a tie, a huge remainder and reloads
        write_num_blocks(4);
        push_request(KIND_LOAD, 5'd0, '0);
        push_request(KIND_LOAD, 5'd1, '1);
        push_request(KIND_LOAD, 5'd2, SIZE_BITS'(10));
        push_request(KIND_LOAD, 5'd3, SIZE_BITS'(10));
        push_request(KIND_ALLOC, 5'd31, '0);
        push_request(KIND_ALLOC, 5'd0, SIZE_BITS'(10));
        push_request(KIND_ALLOC, 5'd0, SIZE_BITS'(10));
        push_request(KIND_ALLOC, 5'd0, SIZE_BITS'(10));
        push_request(KIND_ALLOC, 5'd0, SIZE_BITS'(1));
        push_request(KIND_LOAD, 5'd2, SIZE_BITS'(5));
        push_request(KIND_ALLOC, 5'd0, SIZE_BITS'(3));
        push_request(KIND_LOAD, 5'd1, '1);
        push_request(KIND_ALLOC, 5'd0, '1);
        push_request(KIND_LOAD, 5'd0, SIZE_BITS'(7));
        push_request(KIND_ALLOC, 5'd0, SIZE_BITS'(8));
        push_request(KIND_ALLOC, 5'd0, SIZE_BITS'(7));

        // fill the whole table so that any search span reads loaded entries
        for (int j = 0; j < MAX_BLOCKS; j++)
            push_request(KIND_LOAD, INDEX_FIELD_W'(j),
                         (j % 2) ? SIZE_BITS'($urandom) : SIZE_BITS'($urandom_range(0, 63)));

        // random phases over several search spans, the last one without idling
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p == PHASE_COUNT - 1)
                calm = 1'b1;
            if (phase_settings[p] == PICK_RANDOM)
                write_num_blocks($urandom_range(0, (1 << CFG_W) - 1));
            else
                write_num_blocks(phase_settings[p]);
            repeat (PHASE_ITEMS) random_request();
        end

        settle();
        repeat (RESULT_LATENCY) @(negedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
